### rtl/btrl_pkg.sv
// Shared types and constants for the binary trie route lookup block.
// No dependencies; every other file of the block depends on this package.
package btrl_pkg;

  // Trie and key sizes
  localparam int NODE_COUNT = 4096;
  localparam int ADDR_BITS  = 32;
  localparam int PORT_BITS  = 8;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LEVEL_W    = $clog2(ADDR_BITS + 1);

  // Result status codes
  typedef enum logic [2:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_INSERTED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Command codes
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } command_e;

  // Request word
  typedef struct packed {
    logic        command;
    logic [31:0] key_bits;
    logic [31:0] prefix_mask;
    logic [31:0] route_next_hop;
    logic [7:0]  route_port;
  } req_t;

  // Response word
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_next_hop;
    logic [7:0]  found_port;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;
  } dp_sts_t;

  // Count set bits of a mask; gives the prefix length
  function automatic logic [LEVEL_W-1:0] popcount(input logic [ADDR_BITS-1:0] v);
    logic [LEVEL_W-1:0] n;
    n = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      n = n + LEVEL_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### rtl/btrl_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on btrl_pkg for the payload types.
interface btrl_req_if;
  logic           valid;
  logic           ready;
  btrl_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface btrl_rsp_if;
  logic           valid;
  logic           ready;
  btrl_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/btrl_ctrl.sv
// Controller state machine: sequences load, trie walk and response hand-off.
// Depends on btrl_pkg for the command and status structs.
module btrl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btrl_pkg::ctrl_cmd_t  cmd_o,
  input  btrl_pkg::dp_sts_t    sts_i
);
  import btrl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Decode commands from the current state
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step = (state_q == S_WALK);
    cmd_o.emit = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  // Hold state and the response valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_WALK;
        end
        S_WALK: begin
          if (sts_i.done) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd_o.emit) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/btrl_dp.sv
// Datapath: node pool memories, root node, allocator and one-level-per-cycle walk.
// Depends on btrl_pkg for sizes, payload types and command structs.
module btrl_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  btrl_pkg::req_t       req_data_i,
  output btrl_pkg::rsp_t       rsp_data_o,
  input  btrl_pkg::ctrl_cmd_t  cmd_i,
  output btrl_pkg::dp_sts_t    sts_o
);
  import btrl_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              holds;
  } node_t;

  typedef struct packed {
    logic [31:0]          hop;
    logic [PORT_BITS-1:0] port;
  } route_t;

  // Node pool storage; entry 0 of the link memory is unused (root lives in flops)
  node_t  link_mem  [NODE_COUNT];
  route_t route_mem [NODE_COUNT];
  node_t  link_rd_q;
  route_t route_rd_q;
  node_t  root_q;

  // Walk registers
  logic                 cmd_q;
  logic [ADDR_BITS-1:0] path_q;
  logic [LEVEL_W-1:0]   len_q;
  logic [LEVEL_W-1:0]   level_q;
  logic [NODE_W-1:0]    cur_q;
  logic                 fresh_q;
  logic [FREE_W-1:0]    nfree_q;
  logic                 hit_q;
  route_t               best_q;
  route_t               new_route_q;
  rsp_t                 res_q;
  rsp_t                 out_q;

  // Step signals
  node_t             eff;
  logic [NODE_W-1:0] link;
  logic [NODE_W-1:0] next_node;
  logic [NODE_W-1:0] rd_addr;
  node_t             wr_entry;
  logic              wr_link;
  logic              wr_route;
  logic              adv;
  logic              alloc;
  logic              fresh_next;
  logic              done;
  logic              pool_full;
  rsp_t              res_d;

  // Pick the current node's contents: root flops, a fresh empty node or memory
  always_comb begin
    if (cur_q == '0) begin
      eff = root_q;
    end else if (fresh_q) begin
      eff = '0;
    end else begin
      eff = link_rd_q;
    end
  end

  assign link      = path_q[0] ? eff.right : eff.left;
  assign pool_full = (nfree_q == FREE_W'(NODE_COUNT));

  // Work out one trie level
  always_comb begin
    done       = 1'b0;
    wr_entry   = eff;
    wr_link    = 1'b0;
    wr_route   = 1'b0;
    adv        = 1'b0;
    alloc      = 1'b0;
    fresh_next = 1'b0;
    next_node  = link;
    res_d      = '0;
    if (cmd_q == CMD_LOOKUP) begin
      if ((level_q == LEVEL_W'(ADDR_BITS)) || (link == '0)) begin
        done = 1'b1;
        if (eff.holds) begin
          res_d.status         = ST_HIT;
          res_d.found_next_hop = route_rd_q.hop;
          res_d.found_port     = 8'(route_rd_q.port);
        end else if (hit_q) begin
          res_d.status         = ST_HIT;
          res_d.found_next_hop = best_q.hop;
          res_d.found_port     = 8'(best_q.port);
        end else begin
          res_d.status = ST_MISS;
        end
      end else begin
        adv = 1'b1;
      end
    end else if (len_q == '0) begin
      done         = 1'b1;
      res_d.status = ST_IGNORED;
    end else begin
      // Write the current entry back each level so a fresh node lands in memory
      wr_link = 1'b1;
      if (level_q == len_q) begin
        wr_entry.holds = 1'b1;
        wr_route       = 1'b1;
        done           = 1'b1;
        res_d.status   = ST_INSERTED;
      end else if (link == '0) begin
        if (pool_full) begin
          done         = 1'b1;
          res_d.status = ST_FULL;
        end else begin
          alloc      = 1'b1;
          adv        = 1'b1;
          fresh_next = 1'b1;
          next_node  = nfree_q[NODE_W-1:0];
          if (path_q[0]) begin
            wr_entry.right = nfree_q[NODE_W-1:0];
          end else begin
            wr_entry.left = nfree_q[NODE_W-1:0];
          end
        end
      end else begin
        adv = 1'b1;
      end
    end
  end

  assign sts_o.done = cmd_i.step && done;
  assign rd_addr    = cmd_i.load ? '0 : next_node;
  assign rsp_data_o = out_q;

  // Node pool memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && wr_link && (cur_q != '0)) begin
      link_mem[cur_q] <= wr_entry;
    end
    if (cmd_i.step && wr_route) begin
      route_mem[cur_q] <= new_route_q;
    end
    link_rd_q  <= link_mem[rd_addr];
    route_rd_q <= route_mem[rd_addr];
  end

  // Root node and allocator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      nfree_q <= FREE_W'(1);
    end else if (cmd_i.step) begin
      if (wr_link && (cur_q == '0)) root_q <= wr_entry;
      if (alloc) nfree_q <= nfree_q + FREE_W'(1);
    end
  end

  // Walk registers: load a request word, then advance one level per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_LOOKUP;
      level_q <= '0;
      cur_q   <= '0;
      fresh_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (cmd_i.load) begin
      cmd_q   <= req_data_i.command;
      level_q <= '0;
      cur_q   <= '0;
      fresh_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (cmd_i.step) begin
      if (cmd_q == CMD_LOOKUP && eff.holds) hit_q <= 1'b1;
      if (adv) begin
        cur_q   <= next_node;
        level_q <= level_q + LEVEL_W'(1);
        fresh_q <= fresh_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (req_data_i.command == CMD_INSERT) begin
        path_q <= req_data_i.key_bits[ADDR_BITS-1:0] & req_data_i.prefix_mask[ADDR_BITS-1:0];
      end else begin
        path_q <= req_data_i.key_bits[ADDR_BITS-1:0];
      end
      len_q            <= popcount(req_data_i.prefix_mask[ADDR_BITS-1:0]);
      new_route_q.hop  <= req_data_i.route_next_hop;
      new_route_q.port <= req_data_i.route_port[PORT_BITS-1:0];
    end else if (cmd_i.step) begin
      if (adv) path_q <= path_q >> 1;
      if (cmd_q == CMD_LOOKUP && eff.holds) best_q <= route_rd_q;
      if (done) res_q <= res_d;
    end
    if (cmd_i.emit) out_q <= res_q;
  end

  // The allocator never passes the pool end nor hands out the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfree_q >= FREE_W'(1)) && (nfree_q <= FREE_W'(NODE_COUNT)))
    else $error("allocator pointer out of range");

  // A fresh node is always the most recently allocated one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q |-> (FREE_W'(cur_q) == nfree_q - FREE_W'(1)))
    else $error("fresh node is not the last allocation");

  // The walk never steps deeper than the address width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (level_q <= LEVEL_W'(ADDR_BITS)))
    else $error("walk level beyond address width");

  // An insert never stores a route in the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && wr_route) |-> (cur_q != '0))
    else $error("route written to root node");

endmodule

### rtl/binary_trie_route_lookup.sv
// Binary trie longest-prefix-match route table over a pool of 4096 nodes.
// A lookup or insert is loaded, then walks the trie one level per cycle (one
// node read from the link memory per level, down to the full 32-bit key
// depth at most), then hands the result to the output register. One word is
// worked on at a time; the next word is accepted while the previous result
// still waits in the output register. Nodes are never freed; when the pool
// is exhausted an insert answers pool full.
// Depends on btrl_pkg, btrl_if, btrl_ctrl and btrl_dp.
module binary_trie_route_lookup (
  input  logic              clk_i,
  input  logic              rst_ni,
  btrl_req_if.sink          req_i,
  btrl_rsp_if.source        rsp_o
);
  import btrl_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequence the walk
  btrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold the trie and walk it
  btrl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_data_i (req_i.data),
    .rsp_data_o (rsp_o.data),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
